FILE: rtl/core/rtfc_pkg.sv
`timescale 1ns / 1ps

package rtfc_pkg;

    // table depth default
    localparam int MAX_REGIONS_DEF = 16;

    // page geometry
    localparam logic [31:0] PAGE_MASK = 32'hFFFF_F000;

    // permission bit positions
    localparam int PERM_READ  = 0;
    localparam int PERM_WRITE = 1;
    localparam int PERM_EXEC  = 2;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_RELEASE = 2'd1,
        OP_RESIZE  = 2'd2,
        OP_FAULT   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ACT_ANON         = 3'd0,
        ACT_FILE         = 3'd1,
        ACT_DELAYED      = 3'd2,
        ACT_UNMAPPED     = 3'd3,
        ACT_NOT_WRITABLE = 3'd4,
        ACT_NOT_READABLE = 3'd5,
        ACT_NOT_EXEC     = 3'd6,
        ACT_UNMANAGED    = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ACC_READ  = 2'd0,
        ACC_WRITE = 2'd1,
        ACC_EXEC  = 2'd2,
        ACC_OTHER = 2'd3
    } access_t;

    typedef enum logic [1:0] {
        KIND_ANON    = 2'd0,
        KIND_FILE    = 2'd1,
        KIND_DELAYED = 2'd2,
        KIND_OTHER   = 2'd3
    } region_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REL_RD,
        S_REL_WR,
        S_RSZ_RD,
        S_RSZ_WR,
        S_FLT_SCAN,
        S_FLT_OFS,
        S_FINISH
    } state_t;

    // one table entry
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] length;
        logic [2:0]  perms;
        logic [1:0]  kind;
    } region_t;

    // length rounded up to a whole page, modulo 2^32
    function automatic logic [31:0] page_roundup(input logic [31:0] n);
        logic [19:0] hi;
        hi = n[31:12] + 20'(|n[11:0]);
        return {hi, 12'h000};
    endfunction

endpackage

FILE: rtl/core/region_table_fault_classifier_unit.sv
`timescale 1ns / 1ps
// insert: entry written from idle, then S_FINISH; resize: S_RSZ_RD, S_RSZ_WR, then S_FINISH
// release at index i: an S_REL_RD read and an S_REL_WR write per moved entry, then S_FINISH
// fault check with n regions: scans the n regions, one region per cycle through the
// shared adder (end = base + page-rounded length); a mapped-file hit adds the S_FLT_OFS step
// one item at a time; the next input beat is taken once the result sits in the output register
// reset: region count cleared, table contents undefined until written, no clearing pass

module region_table_fault_classifier_unit
    import rtfc_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         operation,
    input  logic [31:0]        address,
    input  logic [31:0]        length,
    input  logic [2:0]         permissions,
    input  logic [1:0]         region_type,
    input  logic [3:0]         index,
    input  logic signed [31:0] increment,
    input  logic [1:0]         access_kind,
    input  logic               missing_page,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [2:0]         action,
    output logic [3:0]         slot,
    output logic [31:0]        page_address,
    output logic [31:0]        file_offset,
    output logic               page_writable
);

    localparam int IDX_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
    localparam int WIDE_W = (CNT_W > 4) ? CNT_W : 4;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);

    // control registers
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic               s1_vld_reg, s1_vld_next;
    logic               s2_vld_reg, s2_vld_next;

    // work registers
    logic [CNT_W-1:0]   cur_reg, cur_next;
    logic [31:0]        addr_reg, addr_next;
    logic [31:0]        inc_reg, inc_next;
    logic [1:0]         access_reg, access_next;
    logic               missing_reg, missing_next;
    logic [CNT_W-1:0]   s1_idx_reg, s1_idx_next;
    logic [CNT_W-1:0]   s2_idx_reg, s2_idx_next;
    region_t            s2_entry_reg, s2_entry_next;
    logic [31:0]        s2_end_reg, s2_end_next;

    // result registers
    logic [1:0]         res_status_reg, res_status_next;
    logic [2:0]         res_action_reg, res_action_next;
    logic [3:0]         res_slot_reg, res_slot_next;
    logic [31:0]        res_page_reg, res_page_next;
    logic [31:0]        res_foff_reg, res_foff_next;
    logic               res_wr_reg, res_wr_next;

    // output registers
    logic [1:0]         status_reg, status_next;
    logic [2:0]         action_reg, action_next;
    logic [3:0]         slot_reg, slot_next;
    logic [31:0]        page_reg, page_next;
    logic [31:0]        foff_reg, foff_next;
    logic               wr_reg, wr_next;

    // region table
    region_t            mem [MAX_REGIONS];
    region_t            rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    region_t            wr_data;

    // shared adder
    logic [31:0]        add_a, add_b, add_sum;
    logic               add_cin;

    logic [CNT_W-1:0]   cur_inc;
    logic [WIDE_W-1:0]  index_wide, count_wide;
    logic               out_free;
    logic               hit;
    logic [2:0]         cls_action;
    logic               cls_wr;

    assign cur_inc    = cur_reg + CNT_W'(1);
    assign index_wide = WIDE_W'(index);
    assign count_wide = WIDE_W'(count_reg);
    assign out_free   = !out_valid_reg || !out_stall;
    assign add_sum    = add_a + add_b + 32'(add_cin);

    // table read and write ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // read address
    always_comb
    begin
        if (state_reg == S_REL_RD)
        begin
            rd_addr = cur_inc[IDX_W-1:0];
        end
        else
        begin
            rd_addr = cur_reg[IDX_W-1:0];
        end
    end

    // adder operand select
    always_comb
    begin
        add_a   = rd_data_reg.length;
        add_b   = inc_reg;
        add_cin = 1'b0;
        case (state_reg)
            S_FLT_SCAN:
            begin
                add_a = rd_data_reg.base;
                add_b = page_roundup(rd_data_reg.length);
            end
            S_FLT_OFS:
            begin
                add_a   = res_page_reg;
                add_b   = ~s2_entry_reg.base;
                add_cin = 1'b1;
            end
            default:
            begin
                add_a = rd_data_reg.length;
            end
        endcase
    end

    // region match and access classification
    always_comb
    begin
        hit = s2_vld_reg && (addr_reg >= s2_entry_reg.base) && (addr_reg < s2_end_reg);
        cls_wr = 1'b0;
        if (access_reg == ACC_WRITE && !s2_entry_reg.perms[PERM_WRITE])
        begin
            cls_action = ACT_NOT_WRITABLE;
        end
        else if (access_reg == ACC_READ && !s2_entry_reg.perms[PERM_READ])
        begin
            cls_action = ACT_NOT_READABLE;
        end
        else if (access_reg == ACC_EXEC && !s2_entry_reg.perms[PERM_EXEC])
        begin
            cls_action = ACT_NOT_EXEC;
        end
        else if (missing_reg && s2_entry_reg.kind != KIND_OTHER)
        begin
            cls_action = {1'b0, s2_entry_reg.kind};
            cls_wr     = s2_entry_reg.perms[PERM_WRITE];
        end
        else
        begin
            cls_action = ACT_UNMANAGED;
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && out_stall;
        s1_vld_next     = s1_vld_reg;
        s2_vld_next     = s2_vld_reg;
        cur_next        = cur_reg;
        addr_next       = addr_reg;
        inc_next        = inc_reg;
        access_next     = access_reg;
        missing_next    = missing_reg;
        s1_idx_next     = s1_idx_reg;
        s2_idx_next     = s2_idx_reg;
        s2_entry_next   = s2_entry_reg;
        s2_end_next     = s2_end_reg;
        res_status_next = res_status_reg;
        res_action_next = res_action_reg;
        res_slot_next   = res_slot_reg;
        res_page_next   = res_page_reg;
        res_foff_next   = res_foff_reg;
        res_wr_next     = res_wr_reg;
        status_next     = status_reg;
        action_next     = action_reg;
        slot_next       = slot_reg;
        page_next       = page_reg;
        foff_next       = foff_reg;
        wr_next         = wr_reg;
        wr_en           = 1'b0;
        wr_addr         = cur_reg[IDX_W-1:0];
        wr_data         = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_status_next = ST_OK;
                    res_action_next = ACT_ANON;
                    res_slot_next   = 4'd0;
                    res_page_next   = 32'd0;
                    res_foff_next   = 32'd0;
                    res_wr_next     = 1'b0;
                    addr_next       = address;
                    inc_next        = increment;
                    access_next     = access_kind;
                    missing_next    = missing_page;
                    case (operation)
                        OP_INSERT:
                        begin
                            state_next = S_FINISH;
                            if (count_reg == CNT_MAX)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                wr_addr       = count_reg[IDX_W-1:0];
                                wr_data       = '{base: address, length: length,
                                                  perms: permissions, kind: region_type};
                                count_next    = count_reg + CNT_W'(1);
                                res_slot_next = count_wide[3:0];
                            end
                        end
                        OP_RELEASE, OP_RESIZE:
                        begin
                            if (index_wide >= count_wide)
                            begin
                                res_status_next = ST_BAD_INDEX;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                cur_next   = index_wide[CNT_W-1:0];
                                state_next = (operation == OP_RELEASE) ? S_REL_RD : S_RSZ_RD;
                            end
                        end
                        default:
                        begin
                            res_page_next = address & PAGE_MASK;
                            cur_next      = '0;
                            s1_vld_next   = 1'b0;
                            s2_vld_next   = 1'b0;
                            state_next    = S_FLT_SCAN;
                        end
                    endcase
                end
            end

            // close the gap: read entry cur+1, write it at cur
            S_REL_RD:
            begin
                if (cur_inc < count_reg)
                begin
                    state_next = S_REL_WR;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_FINISH;
                end
            end
            S_REL_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = cur_reg[IDX_W-1:0];
                wr_data    = rd_data_reg;
                cur_next   = cur_inc;
                state_next = S_REL_RD;
            end

            // length update through the shared adder
            S_RSZ_RD:
            begin
                state_next = S_RSZ_WR;
            end
            S_RSZ_WR:
            begin
                wr_en          = 1'b1;
                wr_addr        = cur_reg[IDX_W-1:0];
                wr_data        = rd_data_reg;
                wr_data.length = add_sum;
                state_next     = S_FINISH;
            end

            // scan pipeline: read, region end, compare
            S_FLT_SCAN:
            begin
                if (hit)
                begin
                    res_slot_next   = 4'(s2_idx_reg);
                    res_action_next = cls_action;
                    res_wr_next     = cls_wr;
                    state_next      = (cls_action == ACT_FILE) ? S_FLT_OFS : S_FINISH;
                end
                else if (!s1_vld_reg && !s2_vld_reg && cur_reg >= count_reg)
                begin
                    res_action_next = ACT_UNMAPPED;
                    state_next      = S_FINISH;
                end
                else
                begin
                    s2_vld_next   = s1_vld_reg;
                    s2_idx_next   = s1_idx_reg;
                    s2_entry_next = rd_data_reg;
                    s2_end_next   = add_sum;
                    if (cur_reg < count_reg)
                    begin
                        s1_vld_next = 1'b1;
                        s1_idx_next = cur_reg;
                        cur_next    = cur_inc;
                    end
                    else
                    begin
                        s1_vld_next = 1'b0;
                    end
                end
            end

            // file offset = page - base
            S_FLT_OFS:
            begin
                res_foff_next = add_sum;
                state_next    = S_FINISH;
            end

            // hand the result to the output register
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    action_next    = res_action_reg;
                    slot_next      = res_slot_reg;
                    page_next      = res_page_reg;
                    foff_next      = res_foff_reg;
                    wr_next        = res_wr_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            s1_vld_reg    <= s1_vld_next;
            s2_vld_reg    <= s2_vld_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        addr_reg       <= addr_next;
        inc_reg        <= inc_next;
        access_reg     <= access_next;
        missing_reg    <= missing_next;
        s1_idx_reg     <= s1_idx_next;
        s2_idx_reg     <= s2_idx_next;
        s2_entry_reg   <= s2_entry_next;
        s2_end_reg     <= s2_end_next;
        res_status_reg <= res_status_next;
        res_action_reg <= res_action_next;
        res_slot_reg   <= res_slot_next;
        res_page_reg   <= res_page_next;
        res_foff_reg   <= res_foff_next;
        res_wr_reg     <= res_wr_next;
        status_reg     <= status_next;
        action_reg     <= action_next;
        slot_reg       <= slot_next;
        page_reg       <= page_next;
        foff_reg       <= foff_next;
        wr_reg         <= wr_next;
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign action        = action_reg;
    assign slot          = slot_reg;
    assign page_address  = page_reg;
    assign file_offset   = foff_reg;
    assign page_writable = wr_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("region count above table depth");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && operation == OP_INSERT && count_reg != CNT_MAX)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the table");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLT_SCAN && s2_vld_reg) |-> s2_idx_reg < count_reg)
        else $error("scan compared an entry beyond the count");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FINISH)
        else $error("output beat raised outside the finish step");

    a_unmapped_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && action_reg == ACT_UNMAPPED)
        |-> (slot_reg == 4'd0 && foff_reg == 32'd0 && !wr_reg))
        else $error("unmapped result carries region fields");

endmodule
